@@ sv/dsi_pkg.sv @@
`default_nettype none

package dsi_pkg;

   localparam int MAX_CHARS = 11;

   localparam int CH_W      = 8;
   localparam int POS_W     = 8;
   localparam int MAG_W     = 33;
   localparam int ACC_W     = MAG_W + 4;
   localparam int VAL_W     = 32;
   localparam int LIMIT_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_CHARS - 1);

   localparam logic [MAG_W-1:0] MAG_CAP    = 33'h1_0000_0000;
   localparam logic [MAG_W-1:0] LIM_WIDE   = 33'h0_7fff_ffff;
   localparam logic [MAG_W-1:0] LIM_NARROW = 33'h0_0000_7fff;

   localparam logic signed [VAL_W-1:0] NARROW_MIN = -32'sd32768;
   localparam logic signed [VAL_W-1:0] NARROW_MAX = 32'sd32767;

   localparam logic [CSR_IDX_W-1:0] CSR_CONVERT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_ZEROS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW_MODE   = 2'd2;

   typedef enum logic [2:0] {
      PH_START,
      PH_FIRST,
      PH_ZERO1,
      PH_ZEROS,
      PH_DIGITS,
      PH_DONE_OK,
      PH_DONE_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      MAG_KEEP,
      MAG_LOAD,
      MAG_ACC
   } mag_op_type;

endpackage

`default_nettype wire

@@ sv/dsi_if.sv @@
`default_nettype none

interface dsi_req_if;
   import dsi_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface dsi_rsp_if;
   import dsi_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, output ok, output value, input ready);
   modport sink   (input valid, input ok, input value, output ready);
endinterface

interface dsi_csr_if;
   import dsi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/decimal_string_to_int_parser.sv @@
// channel   dir   payload                   handshake
// req_chan  in    ch[7:0]                   valid / ready
// rsp_chan  out   ok, value[31:0] signed    valid / ready
// csr_chan  in    index[1:0], data[7:0]     valid / ready
//
// one character per cycle while no terminator waits; a result for an accepted terminator
// passes the input register, then the result register
// a terminator waits in the input register only while the result register holds
// an item not yet taken; other characters never wait
// reset is synchronous: clears phase, position, sign, accumulator, configuration
// and valid flags
`default_nettype none

module decimal_string_to_int_parser (
   input  logic      clock,
   input  logic      reset,
   dsi_req_if.sink   req_chan,
   dsi_rsp_if.source rsp_chan,
   dsi_csr_if.sink   csr_chan
);
   import dsi_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic               allow_zeros_ff;
   logic               narrow_ff;

   logic               s1_valid_ff;
   logic [CH_W-1:0]    s1_ch_ff;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               neg_ff, neg_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic               term;
   logic               is_digit;
   logic [3:0]         digit;
   logic               rsp_free;
   logic               s1_go;
   logic               fin;
   logic               good;
   logic               set_neg;
   mag_op_type         mag_op;
   logic [ACC_W-1:0]   acc;
   logic [MAG_W-1:0]   lim;
   logic               fits;
   logic [VAL_W-1:0]   mag_lo;

   assign term     = (s1_ch_ff == CH_NUL);
   assign is_digit = (s1_ch_ff >= CH_ZERO) && (s1_ch_ff <= CH_NINE);
   assign digit    = s1_ch_ff[3:0];

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff && (!term || rsp_free);

   assign req_chan.ready = !reset && (!s1_valid_ff || s1_go);
   assign csr_chan.ready = !reset;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= '0;
         allow_zeros_ff <= 1'b0;
         narrow_ff      <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         if (csr_chan.index == CSR_CONVERT_LIMIT) begin
            limit_ff <= csr_chan.data[LIMIT_W-1:0];
         end
         if (csr_chan.index == CSR_ALLOW_ZEROS) begin
            allow_zeros_ff <= csr_chan.data[0];
         end
         if (csr_chan.index == CSR_NARROW_MODE) begin
            narrow_ff <= csr_chan.data[0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_ch_ff <= req_chan.ch;
      end
   end

   // next phase and step decode
   always_comb begin
      phase_in = phase_ff;
      fin      = 1'b0;
      good     = 1'b0;
      set_neg  = 1'b0;
      mag_op   = MAG_KEEP;
      unique case (phase_ff)
         PH_START, PH_FIRST: begin
            if (phase_ff == PH_START && s1_ch_ff == CH_MINUS) begin
               phase_in = PH_FIRST;
               set_neg  = 1'b1;
            end else if (term) begin
               fin = 1'b1;
            end else if (s1_ch_ff == CH_ZERO) begin
               mag_op   = MAG_LOAD;
               phase_in = (limit_ff == LIMIT_W'(1)) ? PH_DONE_OK : PH_ZERO1;
            end else if (is_digit) begin
               mag_op   = MAG_LOAD;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE_FAIL;
            end
         end
         PH_ZERO1, PH_ZEROS: begin
            if (phase_ff == PH_ZERO1 && term) begin
               fin  = 1'b1;
               good = 1'b1;
            end else if (phase_ff == PH_ZERO1 && !allow_zeros_ff) begin
               phase_in = PH_DONE_FAIL;
            end else if (pos_ff > POS_LAST) begin
               phase_in = PH_DONE_FAIL;
               fin      = term;
            end else if (s1_ch_ff == CH_ZERO) begin
               phase_in = PH_ZEROS;
            end else if (term) begin
               fin  = 1'b1;
               good = 1'b1;
            end else if (is_digit) begin
               mag_op   = MAG_LOAD;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE_FAIL;
            end
         end
         PH_DIGITS: begin
            if (limit_ff != '0 && pos_ff >= POS_W'(limit_ff)) begin
               phase_in = PH_DONE_OK;
               fin      = term;
               good     = 1'b1;
            end else if (term) begin
               fin  = 1'b1;
               good = 1'b1;
            end else if (pos_ff > POS_LAST || !is_digit) begin
               phase_in = PH_DONE_FAIL;
            end else begin
               mag_op = MAG_ACC;
            end
         end
         PH_DONE_OK: begin
            fin  = term;
            good = 1'b1;
         end
         default: begin
            phase_in = PH_DONE_FAIL;
            fin      = term;
         end
      endcase
      if (fin) begin
         phase_in = PH_START;
      end
   end

   // accumulator, sign, position and result
   always_comb begin
      acc    = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + ACC_W'(digit);
      lim    = (narrow_ff ? LIM_NARROW : LIM_WIDE) + MAG_W'(neg_ff);
      fits   = good && (mag_ff <= lim);
      mag_lo = mag_ff[VAL_W-1:0];

      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
      neg_in = neg_ff || set_neg;
      unique case (mag_op)
         MAG_LOAD: mag_in = MAG_W'(digit);
         MAG_ACC:  mag_in = (acc > ACC_W'(MAG_CAP)) ? MAG_CAP : acc[MAG_W-1:0];
         default:  mag_in = mag_ff;
      endcase
      if (fin) begin
         pos_in = '0;
         neg_in = 1'b0;
         mag_in = '0;
      end

      rsp_ok_in    = fits;
      rsp_value_in = fits ? (neg_ff ? (VAL_W'(0) - mag_lo) : mag_lo) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else if (s1_go) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s1_go && fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && fin) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ok    = rsp_ok_ff;
   assign rsp_chan.value = rsp_value_ff;

endmodule

`default_nettype wire

@@ sv/dsi_checker.sv @@
`default_nettype none

module dsi_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [dsi_pkg::CH_W-1:0]             req_ch,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_ok,
   input logic signed [dsi_pkg::VAL_W-1:0]     rsp_value,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [dsi_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [dsi_pkg::CSR_DAT_W-1:0]        csr_data
);
   import dsi_pkg::*;

   logic narrow_ff;
   logic term_acc;

   assign term_acc = req_valid && req_ready && (req_ch == CH_NUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_ff <= 1'b0;
      end else if (csr_valid && csr_ready && csr_index == CSR_NARROW_MODE) begin
         narrow_ff <= csr_data[0];
      end
   end

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_value))
      else $error("result changed while stalled");

   // failed parse reports zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value == '0)
      else $error("failed item carries nonzero value");

   // a fresh result traces back to an accepted terminator, through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(term_acc, 2))
      else $error("result without terminator");

   // narrow mode keeps values in 16-bit range
   a_narrow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok && narrow_ff |-> rsp_value >= NARROW_MIN && rsp_value <= NARROW_MAX)
      else $error("value out of narrow range");

endmodule

bind decimal_string_to_int_parser dsi_checker u_dsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_ch    (req_chan.ch),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_ok    (rsp_chan.ok),
   .rsp_value (rsp_chan.value),
   .csr_valid (csr_chan.valid),
   .csr_ready (csr_chan.ready),
   .csr_index (csr_chan.index),
   .csr_data  (csr_chan.data)
);

`default_nettype wire

@@ bench/dsi_result_checker.sv @@
`timescale 1ns / 100ps

module dsi_result_checker
   import dsi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dsi_req_if   req_mon,
   dsi_rsp_if   rsp_mon,
   dsi_csr_if   csr_mon,
   output int   outstanding,
   output int   fail_count
);

   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] value;
   } parse_result_type;

   parse_result_type parsed_q[$];
   parse_result_type parsed_next;
   parse_result_type want;

   logic [LIMIT_W-1:0] limit_cfg;
   logic               allow_cfg;
   logic               narrow_cfg;

   phase_type          phase;
   logic [POS_W-1:0]   position;
   logic               negative;
   logic [ACC_W-1:0]   magnitude;

   function automatic bit is_digit(input logic [CH_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void clear_run();
      phase     = PH_START;
      position  = '0;
      negative  = 1'b0;
      magnitude = '0;
   endfunction

   function automatic bit close_string(input bit good);
      logic [MAG_W-1:0] lim;
      logic [VAL_W-1:0] v;
      lim = narrow_cfg ? LIM_NARROW : LIM_WIDE;
      if (negative) lim = lim + 1'b1;
      v = '0;
      if (good && magnitude <= ACC_W'(lim)) begin
         v = magnitude[VAL_W-1:0];
         if (negative) v = -v;
         parsed_next.ok = 1'b1;
      end else begin
         parsed_next.ok = 1'b0;
      end
      parsed_next.value = v;
      clear_run();
      return 1'b1;
   endfunction

   function automatic void take_first_digit(input logic [CH_W-1:0] c);
      if (is_digit(c)) begin
         magnitude = ACC_W'(c - CH_ZERO);
         phase     = PH_DIGITS;
      end else begin
         phase = PH_DONE_FAIL;
      end
   endfunction

   // returns 1 when the character closes a string and parsed_next holds its result
   function automatic bit parse_char(input logic [CH_W-1:0] c);
      logic [POS_W-1:0] q;
      bit               term;
      phase_type        step;
      q    = position;
      term = (c == CH_NUL);
      if (position != POS_MAX) position = position + 1'b1;
      step = phase;
      if (step == PH_START) begin
         if (c == CH_MINUS) begin
            negative = 1'b1;
            phase    = PH_FIRST;
            return 1'b0;
         end
         step = PH_FIRST;
      end
      if (step == PH_FIRST) begin
         if (term) return close_string(1'b0);
         if (c == CH_ZERO) begin
            magnitude = '0;
            phase     = (limit_cfg == LIMIT_W'(1)) ? PH_DONE_OK : PH_ZERO1;
         end else begin
            take_first_digit(c);
         end
         return 1'b0;
      end
      if (step == PH_ZERO1) begin
         if (term) return close_string(1'b1);
         if (!allow_cfg) begin
            phase = PH_DONE_FAIL;
            return 1'b0;
         end
         step = PH_ZEROS;
      end
      if (step == PH_ZEROS) begin
         if (q > POS_LAST) begin
            phase = PH_DONE_FAIL;
            if (term) return close_string(1'b0);
            return 1'b0;
         end
         if (c == CH_ZERO) begin
            phase = PH_ZEROS;
            return 1'b0;
         end
         if (term) return close_string(1'b1);
         take_first_digit(c);
         return 1'b0;
      end
      case (step)
         PH_DIGITS: begin
            if (limit_cfg != '0 && q >= limit_cfg) begin
               phase = PH_DONE_OK;
               if (term) return close_string(1'b1);
               return 1'b0;
            end
            if (term) return close_string(1'b1);
            if (q > POS_LAST || !is_digit(c)) begin
               phase = PH_DONE_FAIL;
               return 1'b0;
            end
            magnitude = magnitude * ACC_W'(10) + ACC_W'(c - CH_ZERO);
            if (magnitude > ACC_W'(MAG_CAP)) magnitude = ACC_W'(MAG_CAP);
            return 1'b0;
         end
         PH_DONE_OK: begin
            if (term) return close_string(1'b1);
            return 1'b0;
         end
         default: begin
            phase = PH_DONE_FAIL;
            if (term) return close_string(1'b0);
            return 1'b0;
         end
      endcase
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         limit_cfg  = '0;
         allow_cfg  = 1'b0;
         narrow_cfg = 1'b0;
         clear_run();
         parsed_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_CONVERT_LIMIT: limit_cfg  = csr_mon.data;
               CSR_ALLOW_ZEROS:   allow_cfg  = csr_mon.data[0];
               CSR_NARROW_MODE:   narrow_cfg = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (parse_char(req_mon.ch)) parsed_q.insert(parsed_q.size(), parsed_next);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (parsed_q.size() == 0) begin
               $error("unexpected item: ok %0b value %0d", rsp_mon.ok, rsp_mon.value);
               fail_count++;
            end else begin
               want = parsed_q.pop_front();
               if (rsp_mon.ok !== want.ok) begin
                  $error("ok mismatch: expected %0b, actual %0b", want.ok, rsp_mon.ok);
                  fail_count++;
               end
               if (rsp_mon.value !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d",
                         $signed(want.value), rsp_mon.value);
                  fail_count++;
               end
            end
         end
         outstanding <= parsed_q.size();
      end
   end

endmodule

@@ bench/decimal_string_to_int_parser_tb.sv @@
`timescale 1ns / 100ps

module decimal_string_to_int_parser_tb;
   import dsi_pkg::*;

   logic clock = 1'b0;
   logic reset;

   int send_gap = 0;
   int recv_gap = 0;
   int items_sent = 0;
   int outstanding;
   int fail_count;

   logic [CH_W-1:0]      text_q[$];
   logic [CSR_IDX_W-1:0] reg_idx[3];
   logic [CSR_DAT_W-1:0] reg_val[3];

   dsi_req_if req_chan ();
   dsi_rsp_if rsp_chan ();
   dsi_csr_if csr_chan ();

   decimal_string_to_int_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   dsi_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_mon     (csr_chan),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_gap);
   end

   task automatic add_char(input logic [CH_W-1:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   task automatic send_char(input logic [CH_W-1:0] c);
      while ($urandom_range(0, 99) < send_gap) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch    <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_char(text_q[i]);
      text_q.delete();
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      foreach (s[i]) add_char(s[i]);
      add_char(CH_NUL);
      send_text();
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_section(input int budget);
      int     stop_at;
      int     kind;
      int     count;
      longint num;
      string  digits;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         text_q.delete();
         if (kind < 85 && $urandom_range(0, 1)) add_char(CH_MINUS);
         if (kind < 12) begin
            case ($urandom_range(0, 7))
               0:       num = 64'd2147483647;
               1:       num = 64'd2147483648;
               2:       num = 64'd32767;
               3:       num = 64'd32768;
               4:       num = 64'd4294967295;
               5:       num = 64'd4294967296;
               6:       num = 64'd99999999999;
               default: num = $urandom_range(0, 65535);
            endcase
            digits = $sformatf("%0d", num);
            foreach (digits[i]) add_char(digits[i]);
         end else if (kind < 85) begin
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 12)) add_char(CH_ZERO);
            end
            count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            repeat (count) add_char(CH_W'(CH_ZERO + $urandom_range(0, 9)));
            // broken string: one stray byte somewhere
            if (kind >= 70) begin
               text_q.insert($urandom_range(0, text_q.size()),
                             ($urandom_range(0, 3) == 0) ? CH_MINUS
                                                         : CH_W'($urandom_range(1, 255)));
            end
         end else begin
            repeat ($urandom_range(0, 8)) add_char(CH_W'($urandom_range(0, 255)));
         end
         add_char(CH_NUL);
         send_text();
      end
   endtask

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reg_idx[0] = CSR_CONVERT_LIMIT;
      reg_idx[1] = CSR_ALLOW_ZEROS;
      reg_idx[2] = CSR_NARROW_MODE;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.ch    <= CH_NUL;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_CONVERT_LIMIT;
      csr_chan.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_gap = 25;
      recv_gap = 53;
      // empty, sign only, lone zero, negative zero, extra zero, most negative
      send_string("");
      send_string("-");
      send_string("0");
      send_string("-0");
      send_string("00");
      send_string("-2147483648");
      text_q.delete();
      add_char(CH_NINE);
      add_char(8'hff);
      add_char(CH_NUL);
      send_text();

      for (int s = 0; s < 9; s++) begin
         drain_results();
         case (s)
            0: begin reg_val[0] = 8'd0;   reg_val[1] = 8'd0; reg_val[2] = 8'd0; end
            1: begin reg_val[0] = 8'd255; reg_val[1] = 8'd1; reg_val[2] = 8'd1; end
            2: begin reg_val[0] = 8'd1;   reg_val[1] = 8'd0; reg_val[2] = 8'd1; end
            3: begin reg_val[0] = 8'd1;   reg_val[1] = 8'd1; reg_val[2] = 8'd0; end
            default: begin
               reg_val[0] = ($urandom_range(0, 3) == 0) ? 8'd255
                                                        : CSR_DAT_W'($urandom_range(0, 13));
               reg_val[1] = CSR_DAT_W'($urandom_range(0, 1));
               reg_val[2] = CSR_DAT_W'($urandom_range(0, 1));
            end
         endcase
         for (int r = 0; r < 3; r++) begin
            csr_chan.valid <= 1'b1;
            csr_chan.index <= reg_idx[r];
            csr_chan.data  <= reg_val[r];
            @(posedge clock);
            while (!csr_chan.ready) @(posedge clock);
         end
         csr_chan.valid <= 1'b0;
         case (s / 3)
            0: begin send_gap = 25; recv_gap = 53; end
            1: begin send_gap = 53; recv_gap = 25; end
            default: begin send_gap = 0; recv_gap = 0; end
         endcase
         run_section(215);
      end

      drain_results();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
